>>> rtl/acp_pkg.sv
// Shared types, codes and lookup functions for the ASCII CAN command parser.
`timescale 1ns / 1ps
`default_nettype none
package acp_pkg;

    localparam int QueueDepth = 2;

    // Result status codes.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_INPUT    = 4'd1;
    localparam logic [3:0] ST_NO_ARG      = 4'd2;
    localparam logic [3:0] ST_BAD_CMD     = 4'd3;
    localparam logic [3:0] ST_TOO_LONG    = 4'd4;
    localparam logic [3:0] ST_BAD_BAUD    = 4'd5;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd6;
    localparam logic [3:0] ST_TOO_SHORT   = 4'd7;
    localparam logic [3:0] ST_BAD_HEX     = 4'd8;
    localparam logic [3:0] ST_STD_OVF     = 4'd9;
    localparam logic [3:0] ST_EXT_OVF     = 4'd10;
    localparam logic [3:0] ST_DLC_RANGE   = 4'd11;
    localparam logic [3:0] ST_ODD_PAYLOAD = 4'd12;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd13;
    localparam logic [3:0] ST_REMOTE_DATA = 4'd14;

    // Operation codes.
    localparam logic [2:0] OP_SEND_FRAME = 3'd0;
    localparam logic [2:0] OP_OPEN       = 3'd1;
    localparam logic [2:0] OP_CLOSE      = 3'd2;
    localparam logic [2:0] OP_SET_BAUD   = 3'd3;
    localparam logic [2:0] OP_FLAG       = 3'd4;
    localparam logic [2:0] OP_VERSION    = 3'd5;
    localparam logic [2:0] OP_SERIAL     = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_S_UP  = 8'h53;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_M_UP  = 8'h4D;
    localparam logic [7:0] CH_M_LO  = 8'h6D;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;
    localparam logic [31:0] EXT_ID_MAX = 32'h1FFF_FFFF;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] code;
        logic       is_cr;
        logic       is_blank;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_char;

    // Saturating count: once at 30 it alternates 30/31 so parity stays exact.
    function automatic logic [4:0] sat_count(input logic [5:0] s);
        logic [4:0] r;
        begin
            if (s >= 6'd30) begin
                r = {4'b1111, s[0]};
            end else begin
                r = s[4:0];
            end
            return r;
        end
    endfunction

    function automatic logic [19:0] baud_lookup(input logic [3:0] sel);
        logic [19:0] r;
        begin
            case (sel)
                4'd0:    r = 20'd10000;
                4'd1:    r = 20'd20000;
                4'd2:    r = 20'd50000;
                4'd3:    r = 20'd100000;
                4'd4:    r = 20'd125000;
                4'd5:    r = 20'd250000;
                4'd6:    r = 20'd500000;
                4'd7:    r = 20'd800000;
                4'd8:    r = 20'd1000000;
                default: r = 20'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/acp_front.sv
// Front end: classifies each received character for the back end.
`timescale 1ns / 1ps
`default_nettype none
module acp_front (
    input  wire logic [7:0]    i_code,
    output acp_pkg::t_char     o_char
);

    always_comb begin
        o_char.code     = i_code;
        o_char.is_cr    = (i_code == acp_pkg::CH_CR);
        o_char.is_blank = (i_code == acp_pkg::CH_SPACE) || (i_code == acp_pkg::CH_TAB) ||
                          (i_code == acp_pkg::CH_LF);
        o_char.is_hex   = 1'b0;
        o_char.hex_val  = 4'd0;
        if (i_code >= 8'h30 && i_code <= 8'h39) begin
            o_char.is_hex  = 1'b1;
            o_char.hex_val = i_code[3:0];
        end else if ((i_code >= 8'h61 && i_code <= 8'h66) ||
                     (i_code >= 8'h41 && i_code <= 8'h46)) begin
            o_char.is_hex  = 1'b1;
            o_char.hex_val = i_code[3:0] + 4'd9;
        end
    end

endmodule
`default_nettype wire

>>> rtl/acp_queue.sv
// Two-entry queue of classified characters between front and back.
`timescale 1ns / 1ps
`default_nettype none
module acp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire acp_pkg::t_char i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output acp_pkg::t_char     o_data
);

    acp_pkg::t_char r_mem [acp_pkg::QueueDepth];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(acp_pkg::QueueDepth));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/acp_back.sv
// Back end: line state, per-character field update and result register.
`timescale 1ns / 1ps
`default_nettype none
module acp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire acp_pkg::t_char i_char,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [3:0]         o_status,
    output logic [2:0]         o_op_kind,
    output logic [28:0]        o_frame_id,
    output logic               o_ext_frame,
    output logic               o_is_remote,
    output logic [3:0]         o_data_length,
    output logic [63:0]        o_payload,
    output logic [19:0]        o_baud_rate
);

    logic        r_line_started, n_line_started;
    logic [7:0]  r_cmd, n_cmd;
    logic [4:0]  r_arg_len, n_arg_len;
    logic [4:0]  r_pend, n_pend;
    logic [31:0] r_id, n_id;
    logic [3:0]  r_len_digit, n_len_digit;
    logic [63:0] r_data, n_data;
    logic [3:0]  r_upper, n_upper;
    logic [3:0]  r_hdr_err, n_hdr_err;
    logic        r_pay_bad, n_pay_bad;

    logic        r_out_valid;
    logic [3:0]  r_status, f_status;
    logic [2:0]  r_op, f_op;
    logic [28:0] r_fid, f_fid;
    logic        r_ext, f_ext;
    logic        r_rem, f_rem;
    logic [3:0]  r_dl, f_dl;
    logic [63:0] r_pay, f_pay;
    logic [19:0] r_baud, f_baud;

    logic        is_frame_cmd;
    logic        is_ext_cmd;
    logic        is_rem_cmd;
    logic [4:0]  idlen;
    logic        pop_cr;

    assign is_ext_cmd   = (r_cmd == acp_pkg::CH_T_UP) || (r_cmd == acp_pkg::CH_R_UP);
    assign is_rem_cmd   = (r_cmd == acp_pkg::CH_R_LO) || (r_cmd == acp_pkg::CH_R_UP);
    assign is_frame_cmd = is_ext_cmd || is_rem_cmd || (r_cmd == acp_pkg::CH_T_LO);
    assign idlen        = is_ext_cmd ? 5'd8 : 5'd3;

    // A line end can leave only when the result register is free or is being read out.
    assign o_pop  = i_in_valid && (!i_char.is_cr || !r_out_valid || i_ready);
    assign pop_cr = o_pop && i_char.is_cr;

    // Per-character state update; pending blanks are folded in before the character.
    always_comb begin
        logic [5:0] sum_b;
        logic [4:0] pos;
        logic [4:0] q;
        logic [7:0] byte_v;
        n_line_started = r_line_started;
        n_cmd          = r_cmd;
        n_arg_len      = r_arg_len;
        n_pend         = r_pend;
        n_id           = r_id;
        n_len_digit    = r_len_digit;
        n_data         = r_data;
        n_upper        = r_upper;
        n_hdr_err      = r_hdr_err;
        n_pay_bad      = r_pay_bad;
        sum_b          = {1'b0, r_arg_len} + {1'b0, r_pend};
        pos            = acp_pkg::sat_count(sum_b);
        q              = pos - idlen - 5'd1;
        byte_v         = {r_upper, i_char.hex_val};
        if (o_pop) begin
            if (i_char.is_cr) begin
                n_line_started = 1'b0;
                n_cmd          = 8'd0;
                n_arg_len      = 5'd0;
                n_pend         = 5'd0;
                n_id           = 32'd0;
                n_len_digit    = 4'd0;
                n_data         = 64'd0;
                n_upper        = 4'd0;
                n_hdr_err      = acp_pkg::ST_OK;
                n_pay_bad      = 1'b0;
            end else if (i_char.is_blank) begin
                if (r_line_started) begin
                    n_pend = acp_pkg::sat_count({1'b0, r_pend} + 6'd1);
                end
            end else if (!r_line_started) begin
                n_line_started = 1'b1;
                n_cmd          = i_char.code;
            end else begin
                // Blanks inside the line are non-hex argument characters.
                if (r_pend != 5'd0) begin
                    if (r_cmd == acp_pkg::CH_S_UP && r_arg_len == 5'd0) begin
                        n_id = {24'd0, acp_pkg::CH_SPACE};
                    end else if (is_frame_cmd) begin
                        if (r_arg_len <= idlen && n_hdr_err == acp_pkg::ST_OK) begin
                            n_hdr_err = acp_pkg::ST_BAD_HEX;
                        end
                        if (sum_b > {1'b0, idlen} + 6'd1) begin
                            n_pay_bad = 1'b1;
                        end
                    end
                end
                if (r_cmd == acp_pkg::CH_S_UP && pos == 5'd0) begin
                    n_id = {24'd0, i_char.code};
                end else if (is_frame_cmd) begin
                    if (pos < idlen) begin
                        if (!i_char.is_hex) begin
                            if (n_hdr_err == acp_pkg::ST_OK) begin
                                n_hdr_err = acp_pkg::ST_BAD_HEX;
                            end
                        end else begin
                            n_id = {r_id[27:0], i_char.hex_val};
                        end
                        if (pos == idlen - 5'd1 && n_hdr_err == acp_pkg::ST_OK) begin
                            if (is_ext_cmd) begin
                                if (n_id > acp_pkg::EXT_ID_MAX) begin
                                    n_hdr_err = acp_pkg::ST_EXT_OVF;
                                end
                            end else if (n_id > acp_pkg::STD_ID_MAX) begin
                                n_hdr_err = acp_pkg::ST_STD_OVF;
                            end
                        end
                    end else if (pos == idlen) begin
                        if (n_hdr_err == acp_pkg::ST_OK) begin
                            if (!i_char.is_hex) begin
                                n_hdr_err = acp_pkg::ST_BAD_HEX;
                            end else if (i_char.hex_val > 4'd8) begin
                                n_hdr_err = acp_pkg::ST_DLC_RANGE;
                            end else begin
                                n_len_digit = i_char.hex_val;
                            end
                        end
                    end else begin
                        if (!i_char.is_hex) begin
                            n_pay_bad = 1'b1;
                        end else if (q < 5'd16) begin
                            if (!q[0]) begin
                                n_upper = i_char.hex_val;
                            end else begin
                                for (int i = 0; i < 8; i++) begin
                                    if (q[3:1] == 3'(i)) begin
                                        n_data[i*8 +: 8] = r_data[i*8 +: 8] | byte_v;
                                    end
                                end
                            end
                        end
                    end
                end
                n_arg_len = acp_pkg::sat_count(sum_b + 6'd1);
                n_pend    = 5'd0;
            end
        end
    end

    // Line-end decode from the collected state.
    always_comb begin
        logic [4:0] plen;
        plen   = r_arg_len - idlen - 5'd1;
        f_status = acp_pkg::ST_OK;
        f_op     = acp_pkg::OP_SEND_FRAME;
        f_fid    = 29'd0;
        f_ext    = 1'b0;
        f_rem    = 1'b0;
        f_dl     = 4'd0;
        f_pay    = 64'd0;
        f_baud   = 20'd0;
        if (!r_line_started) begin
            f_status = acp_pkg::ST_NO_INPUT;
        end else if (r_arg_len == 5'd0) begin
            unique case (r_cmd)
                acp_pkg::CH_F: f_op = acp_pkg::OP_FLAG;
                acp_pkg::CH_V: f_op = acp_pkg::OP_VERSION;
                acp_pkg::CH_N: f_op = acp_pkg::OP_SERIAL;
                acp_pkg::CH_O: f_op = acp_pkg::OP_OPEN;
                acp_pkg::CH_C: f_op = acp_pkg::OP_CLOSE;
                acp_pkg::CH_S_UP, acp_pkg::CH_S_LO, acp_pkg::CH_T_LO, acp_pkg::CH_R_LO,
                acp_pkg::CH_T_UP, acp_pkg::CH_R_UP, acp_pkg::CH_M_UP, acp_pkg::CH_M_LO,
                acp_pkg::CH_Z: f_status = acp_pkg::ST_NO_ARG;
                default: f_status = acp_pkg::ST_BAD_CMD;
            endcase
        end else if (r_cmd == acp_pkg::CH_S_UP) begin
            if (r_arg_len > 5'd1) begin
                f_status = acp_pkg::ST_TOO_LONG;
            end else if (r_id < {24'd0, acp_pkg::CH_ZERO} ||
                         r_id > {24'd0, acp_pkg::CH_EIGHT}) begin
                f_status = acp_pkg::ST_BAD_BAUD;
            end else begin
                f_op   = acp_pkg::OP_SET_BAUD;
                f_baud = acp_pkg::baud_lookup(r_id[3:0]);
            end
        end else if (r_cmd == acp_pkg::CH_S_LO || r_cmd == acp_pkg::CH_M_UP ||
                     r_cmd == acp_pkg::CH_M_LO || r_cmd == acp_pkg::CH_Z) begin
            f_status = acp_pkg::ST_UNSUPPORTED;
        end else if (is_frame_cmd) begin
            if (r_arg_len < idlen + 5'd1) begin
                f_status = acp_pkg::ST_TOO_SHORT;
            end else if (r_hdr_err != acp_pkg::ST_OK) begin
                f_status = r_hdr_err;
            end else if (is_rem_cmd) begin
                if (plen != 5'd0) begin
                    f_status = acp_pkg::ST_REMOTE_DATA;
                end
            end else if (plen[0]) begin
                f_status = acp_pkg::ST_ODD_PAYLOAD;
            end else if (plen != {r_len_digit, 1'b0}) begin
                f_status = acp_pkg::ST_LEN_MISMATCH;
            end else if (r_pay_bad) begin
                f_status = acp_pkg::ST_BAD_HEX;
            end
            if (f_status == acp_pkg::ST_OK) begin
                f_fid = r_id[28:0];
                f_ext = is_ext_cmd;
                f_rem = is_rem_cmd;
                if (!is_rem_cmd) begin
                    f_dl  = r_len_digit;
                    f_pay = r_data;
                end
            end
        end else begin
            f_status = acp_pkg::ST_BAD_CMD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_started <= 1'b0;
            r_cmd          <= 8'd0;
            r_arg_len      <= 5'd0;
            r_pend         <= 5'd0;
            r_id           <= 32'd0;
            r_len_digit    <= 4'd0;
            r_data         <= 64'd0;
            r_upper        <= 4'd0;
            r_hdr_err      <= acp_pkg::ST_OK;
            r_pay_bad      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_line_started <= n_line_started;
            r_cmd          <= n_cmd;
            r_arg_len      <= n_arg_len;
            r_pend         <= n_pend;
            r_id           <= n_id;
            r_len_digit    <= n_len_digit;
            r_data         <= n_data;
            r_upper        <= n_upper;
            r_hdr_err      <= n_hdr_err;
            r_pay_bad      <= n_pay_bad;
            if (pop_cr) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_cr) begin
            r_status <= f_status;
            r_op     <= f_op;
            r_fid    <= f_fid;
            r_ext    <= f_ext;
            r_rem    <= f_rem;
            r_dl     <= f_dl;
            r_pay    <= f_pay;
            r_baud   <= f_baud;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_op_kind     = r_op;
    assign o_frame_id    = r_fid;
    assign o_ext_frame   = r_ext;
    assign o_is_remote   = r_rem;
    assign o_data_length = r_dl;
    assign o_payload     = r_pay;
    assign o_baud_rate   = r_baud;

endmodule
`default_nettype wire

>>> rtl/ascii_can_command_parser.sv
// A line end passes through the queue and then the result register before o_valid rises.
// Throughput: one character per cycle while o_ready is high; the back end retires one queued
// character a cycle; a line end waits in the two-entry queue while the result register is held.
// Reset: synchronous, active low; clears the queue, line state and result valid.
// Top level of the ASCII CAN command parser.
`timescale 1ns / 1ps
`default_nettype none
module ascii_can_command_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_status,
    output logic [2:0]       o_op_kind,
    output logic [28:0]      o_frame_id,
    output logic             o_ext_frame,
    output logic             o_is_remote,
    output logic [3:0]       o_data_length,
    output logic [63:0]      o_payload,
    output logic [19:0]      o_baud_rate
);

    acp_pkg::t_char front_char;
    acp_pkg::t_char q_char;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign o_ready = !q_full;

    acp_front u_front (
        .i_code (i_char_code),
        .o_char (front_char)
    );

    acp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_data  (front_char),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_char)
    );

    acp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (q_valid),
        .i_char        (q_char),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_op_kind     (o_op_kind),
        .o_frame_id    (o_frame_id),
        .o_ext_frame   (o_ext_frame),
        .o_is_remote   (o_is_remote),
        .o_data_length (o_data_length),
        .o_payload     (o_payload),
        .o_baud_rate   (o_baud_rate)
    );

`ifndef SYNTHESIS
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_valid)
        else $error("queue full while empty");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != acp_pkg::ST_OK) |->
        (o_baud_rate == 20'd0 && o_payload == 64'd0 && o_frame_id == 29'd0))
        else $error("error result carries data");

    a_baud_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == acp_pkg::ST_OK && o_op_kind == acp_pkg::OP_SET_BAUD) |->
        (o_baud_rate != 20'd0))
        else $error("set-baud result without a rate");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end took from an empty queue");
`endif

endmodule
`default_nettype wire

>>> dv/ascii_can_command_parser_tb.sv
// Self-checking testbench for the ASCII CAN command parser.
`timescale 1ns / 1ps
module ascii_can_command_parser_tb;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  op_kind;
        logic [28:0] frame_id;
        logic        ext_frame;
        logic        is_remote;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [19:0] baud_rate;
    } t_reply;

    localparam int WatchdogLimit = 5000;
    // A DrainMark entry in the character queue asks the driver to wait for an empty reply queue.
    localparam int DrainMark = -1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_code;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_status;
    logic [2:0]  o_op_kind;
    logic [28:0] o_frame_id;
    logic        o_ext_frame;
    logic        o_is_remote;
    logic [3:0]  o_data_length;
    logic [63:0] o_payload;
    logic [19:0] o_baud_rate;

    ascii_can_command_parser DUT (.*);

    // Parser state mirrored in the predictor.
    logic        p_started;
    logic [7:0]  p_cmd;
    logic [4:0]  p_args;
    logic [4:0]  p_blanks;
    logic [31:0] p_id;
    logic [3:0]  p_dlc;
    logic [63:0] p_data;
    logic [3:0]  p_upper;
    logic [3:0]  p_hdr_err;
    logic        p_bad_char;

    int     char_queue[$];
    t_reply reply_queue[$];
    int     errors;
    int     idle_cycles;
    bit     stim_done;
    int     burst_left;
    int     gap_left;
    int     stall_phase;

    // Transfer seen at the last rising edge, for use by the driver on the falling edge.
    logic o_ready_seen;

    function automatic int hex_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [4:0] bump(input logic [4:0] n);
        int s;
        s = n + 1;
        if (s >= 30) return 5'd30 | 5'(s & 1);
        return 5'(s);
    endfunction

    function automatic bit frame_cmd(input logic [7:0] c);
        return c == acp_pkg::CH_T_LO || c == acp_pkg::CH_T_UP ||
               c == acp_pkg::CH_R_LO || c == acp_pkg::CH_R_UP;
    endfunction

    function automatic bit ext_cmd(input logic [7:0] c);
        return c == acp_pkg::CH_T_UP || c == acp_pkg::CH_R_UP;
    endfunction

    function automatic logic [19:0] rate_of(input int sel);
        case (sel)
            0: return 20'd10000;
            1: return 20'd20000;
            2: return 20'd50000;
            3: return 20'd100000;
            4: return 20'd125000;
            5: return 20'd250000;
            6: return 20'd500000;
            7: return 20'd800000;
            default: return 20'd1000000;
        endcase
    endfunction

    task automatic clear_parser();
        p_started = 0; p_cmd = 0; p_args = 0; p_blanks = 0; p_id = 0;
        p_dlc = 0; p_data = 0; p_upper = 0; p_hdr_err = acp_pkg::ST_OK; p_bad_char = 0;
    endtask

    task automatic absorb_arg(input logic [7:0] c);
        int d;
        int pos;
        int idlen;
        int q;
        pos = p_args;
        d = hex_of(c);
        idlen = ext_cmd(p_cmd) ? 8 : 3;
        if (p_cmd == acp_pkg::CH_S_UP && pos == 0) begin
            p_id = {24'd0, c};
        end else if (frame_cmd(p_cmd)) begin
            if (pos < idlen) begin
                if (d < 0) begin
                    if (p_hdr_err == acp_pkg::ST_OK) p_hdr_err = acp_pkg::ST_BAD_HEX;
                end else begin
                    p_id = (p_id << 4) | 32'(d);
                end
                if (pos == idlen - 1 && p_hdr_err == acp_pkg::ST_OK) begin
                    if (ext_cmd(p_cmd)) begin
                        if (p_id > acp_pkg::EXT_ID_MAX) p_hdr_err = acp_pkg::ST_EXT_OVF;
                    end else if (p_id > acp_pkg::STD_ID_MAX) begin
                        p_hdr_err = acp_pkg::ST_STD_OVF;
                    end
                end
            end else if (pos == idlen) begin
                if (p_hdr_err == acp_pkg::ST_OK) begin
                    if (d < 0) p_hdr_err = acp_pkg::ST_BAD_HEX;
                    else if (d > 8) p_hdr_err = acp_pkg::ST_DLC_RANGE;
                    else p_dlc = 4'(d);
                end
            end else begin
                q = pos - idlen - 1;
                if (d < 0) begin
                    p_bad_char = 1;
                end else if (q < 16) begin
                    if ((q & 1) == 0) p_upper = 4'(d);
                    else p_data |= 64'({p_upper, 4'(d)}) << (8 * (q >> 1));
                end
            end
        end
        p_args = bump(p_args);
    endtask

    function automatic t_reply close_line();
        t_reply r;
        int n;
        int idlen;
        int plen;
        bit rem;
        r = '0;
        n = p_args;
        if (!p_started) begin
            r.status = acp_pkg::ST_NO_INPUT;
        end else if (n == 0) begin
            case (p_cmd)
                acp_pkg::CH_F: r.op_kind = acp_pkg::OP_FLAG;
                acp_pkg::CH_V: r.op_kind = acp_pkg::OP_VERSION;
                acp_pkg::CH_N: r.op_kind = acp_pkg::OP_SERIAL;
                acp_pkg::CH_O: r.op_kind = acp_pkg::OP_OPEN;
                acp_pkg::CH_C: r.op_kind = acp_pkg::OP_CLOSE;
                acp_pkg::CH_S_UP, acp_pkg::CH_S_LO, acp_pkg::CH_T_LO, acp_pkg::CH_R_LO,
                acp_pkg::CH_T_UP, acp_pkg::CH_R_UP, acp_pkg::CH_M_UP, acp_pkg::CH_M_LO,
                acp_pkg::CH_Z: r.status = acp_pkg::ST_NO_ARG;
                default: r.status = acp_pkg::ST_BAD_CMD;
            endcase
        end else if (p_cmd == acp_pkg::CH_S_UP) begin
            if (n > 1) r.status = acp_pkg::ST_TOO_LONG;
            else if (p_id < acp_pkg::CH_ZERO || p_id > acp_pkg::CH_EIGHT) begin
                r.status = acp_pkg::ST_BAD_BAUD;
            end else begin
                r.op_kind = acp_pkg::OP_SET_BAUD;
                r.baud_rate = rate_of(p_id - acp_pkg::CH_ZERO);
            end
        end else if (p_cmd == acp_pkg::CH_S_LO || p_cmd == acp_pkg::CH_M_UP
                     || p_cmd == acp_pkg::CH_M_LO || p_cmd == acp_pkg::CH_Z) begin
            r.status = acp_pkg::ST_UNSUPPORTED;
        end else if (frame_cmd(p_cmd)) begin
            idlen = ext_cmd(p_cmd) ? 8 : 3;
            rem = p_cmd == acp_pkg::CH_R_LO || p_cmd == acp_pkg::CH_R_UP;
            if (n < idlen + 1) r.status = acp_pkg::ST_TOO_SHORT;
            else if (p_hdr_err != acp_pkg::ST_OK) r.status = p_hdr_err;
            else begin
                plen = n - idlen - 1;
                if (rem) begin
                    if (plen != 0) r.status = acp_pkg::ST_REMOTE_DATA;
                end else if (plen & 1) r.status = acp_pkg::ST_ODD_PAYLOAD;
                else if (plen != 2 * p_dlc) r.status = acp_pkg::ST_LEN_MISMATCH;
                else if (p_bad_char) r.status = acp_pkg::ST_BAD_HEX;
                if (r.status == acp_pkg::ST_OK) begin
                    r.op_kind = acp_pkg::OP_SEND_FRAME;
                    r.frame_id = p_id[28:0];
                    r.ext_frame = ext_cmd(p_cmd);
                    r.is_remote = rem;
                    if (!rem) begin
                        r.data_length = p_dlc;
                        r.payload = p_data;
                    end
                end
            end
        end else begin
            r.status = acp_pkg::ST_BAD_CMD;
        end
        if (r.status != acp_pkg::ST_OK) r = '{status: r.status, default: '0};
        return r;
    endfunction

    task automatic predict_char(input logic [7:0] c);
        int k;
        if (c == acp_pkg::CH_CR) begin
            reply_queue.push_back(close_line());
            clear_parser();
        end else if (c == acp_pkg::CH_SPACE || c == acp_pkg::CH_TAB || c == acp_pkg::CH_LF) begin
            if (p_started) p_blanks = bump(p_blanks);
        end else if (!p_started) begin
            p_started = 1;
            p_cmd = c;
        end else begin
            k = p_blanks;
            for (int i = 0; i < k; i++) absorb_arg(acp_pkg::CH_SPACE);
            p_blanks = 0;
            absorb_arg(c);
        end
    endtask

    // Stimulus building blocks.
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        string up;
        string lo;
        up = "0123456789ABCDEF";
        lo = "0123456789abcdef";
        return $urandom_range(0, 1) ? up[v] : lo[v];
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0: return acp_pkg::CH_SPACE;
            1: return 8'($urandom_range(0, 255));
            2: return 8'($urandom_range(128, 255));
            3: return "G";
            4: return acp_pkg::CH_TAB;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic push_blanks();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: char_queue.push_back(acp_pkg::CH_SPACE);
                1: char_queue.push_back(acp_pkg::CH_TAB);
                default: char_queue.push_back(acp_pkg::CH_LF);
            endcase
        end
    endtask

    task automatic push_frame();
        logic [7:0] cmd;
        int idlen;
        int dlc;
        int plen;
        int flaw;
        logic [31:0] id;
        case ($urandom_range(0, 3))
            0: cmd = acp_pkg::CH_T_LO;
            1: cmd = acp_pkg::CH_T_UP;
            2: cmd = acp_pkg::CH_R_LO;
            default: cmd = acp_pkg::CH_R_UP;
        endcase
        idlen = ext_cmd(cmd) ? 8 : 3;
        case ($urandom_range(0, 3))
            0: id = ext_cmd(cmd) ? 32'h1FFF_FFFF : 32'h7FF;
            1: id = 0;
            default: id = ext_cmd(cmd) ? 32'($urandom()) & 32'h1FFF_FFFF
                                       : 32'($urandom_range(0, 2047));
        endcase
        flaw = $urandom_range(0, 9);
        if (flaw == 0) id = $urandom();
        dlc = $urandom_range(0, 8);
        plen = (cmd == acp_pkg::CH_R_LO || cmd == acp_pkg::CH_R_UP) ? 0 : 2 * dlc;
        if (flaw == 1) plen = $urandom_range(0, 20);
        push_blanks();
        char_queue.push_back(cmd);
        for (int i = idlen - 1; i >= 0; i--) begin
            if (flaw == 2 && $urandom_range(0, idlen) == 0) char_queue.push_back(noise_char());
            else char_queue.push_back(hex_char((id >> (4 * i)) & 15));
        end
        if (flaw == 3) char_queue.push_back(hex_char($urandom_range(9, 15)));
        else char_queue.push_back(hex_char(dlc));
        for (int i = 0; i < plen; i++) begin
            if (flaw == 4 && $urandom_range(0, plen) == 0) char_queue.push_back(noise_char());
            else char_queue.push_back(hex_char($urandom_range(0, 15)));
        end
        if (flaw == 5) begin
            repeat ($urandom_range(1, 10)) char_queue.push_back(hex_char($urandom_range(0, 15)));
        end
        if (flaw == 6) repeat ($urandom_range(0, idlen)) void'(char_queue.pop_back());
        push_blanks();
        char_queue.push_back(acp_pkg::CH_CR);
    endtask

    task automatic push_random_line();
        string simple;
        simple = "FVNOCsMmZSX";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: push_frame();
            5: begin
                push_blanks();
                char_queue.push_back("S");
                if ($urandom_range(0, 3) != 0) char_queue.push_back(8'($urandom_range(47, 57)));
                if ($urandom_range(0, 5) == 0) char_queue.push_back(noise_char());
                push_blanks();
                char_queue.push_back(acp_pkg::CH_CR);
            end
            6: begin
                push_blanks();
                char_queue.push_back(simple[$urandom_range(0, simple.len() - 1)]);
                if ($urandom_range(0, 2) == 0) char_queue.push_back(noise_char());
                push_blanks();
                char_queue.push_back(acp_pkg::CH_CR);
            end
            7: begin
                repeat ($urandom_range(0, 40)) char_queue.push_back(noise_char());
                char_queue.push_back(acp_pkg::CH_CR);
            end
            8: char_queue.push_back(8'($urandom_range(0, 255)));
            default: begin
                // Long lines push the counters into saturation.
                char_queue.push_back("t");
                repeat ($urandom_range(28, 40)) char_queue.push_back(hex_char($urandom_range(0, 15)));
                char_queue.push_back(acp_pkg::CH_CR);
            end
        endcase
    endtask

    task automatic check_reply(input t_reply e);
        if (o_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, o_status); errors++;
        end
        if (o_op_kind !== e.op_kind) begin
            $error("op_kind: expected %0d, got %0d", e.op_kind, o_op_kind); errors++;
        end
        if (o_frame_id !== e.frame_id) begin
            $error("frame_id: expected %h, got %h", e.frame_id, o_frame_id); errors++;
        end
        if (o_ext_frame !== e.ext_frame) begin
            $error("ext_frame: expected %0d, got %0d", e.ext_frame, o_ext_frame);
            errors++;
        end
        if (o_is_remote !== e.is_remote) begin
            $error("is_remote: expected %0d, got %0d", e.is_remote, o_is_remote); errors++;
        end
        if (o_data_length !== e.data_length) begin
            $error("data_length: expected %0d, got %0d", e.data_length, o_data_length);
            errors++;
        end
        if (o_payload !== e.payload) begin
            $error("payload: expected %h, got %h", e.payload, o_payload); errors++;
        end
        if (o_baud_rate !== e.baud_rate) begin
            $error("baud_rate: expected %0d, got %0d", e.baud_rate, o_baud_rate); errors++;
        end
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        clear_parser();
        errors = 0;
        stim_done = 0;
        push_text("\r  \t\n\r F\rV\r N \rO\rC\r");
        push_text("S0\rS8\rS9\rS\rS12\rs1\rM\rm1\rZ\rQ\r");
        push_text("t7FF81122334455667788\rt800\rT1FFFFFFF0\rT20000000\r");
        push_text("r1233\rR000000000\rr12304\rt1239\rt123A\rtG230\r");
        push_text("t12320011\rt1232001\rt123200GG\rT1234\rt1 3\r");
        char_queue.push_back(DrainMark);
        while (char_queue.size() < 1600) begin
            push_random_line();
            if ($urandom_range(0, 150) == 0) char_queue.push_back(DrainMark);
        end
        char_queue.push_back(acp_pkg::CH_CR);
    end

    // Driver: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_char_code <= 0;
        end else if (!i_valid || o_ready_seen) begin
            if (char_queue.size() > 0 && char_queue[0] == DrainMark) begin
                if (reply_queue.size() == 0) void'(char_queue.pop_front());
                i_valid <= 0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 0;
            end else if (char_queue.size() > 0) begin
                i_valid <= 1;
                i_char_code <= 8'(char_queue.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 0;
                stim_done <= 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0) i_ready <= 1;
            else if (stall_phase[9:8] == 2'd1) i_ready <= (stall_phase % 5) != 0;
            else i_ready <= $urandom_range(0, 2) != 0;
        end
    end

    // Monitor: predicts on every input transfer, checks every output transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
            o_ready_seen <= 0;
        end else begin
            o_ready_seen <= i_valid && o_ready;
            idle_cycles <= ((i_valid && o_ready) || (o_valid && i_ready)) ? 0
                                                                          : idle_cycles + 1;
            if (i_valid && o_ready) begin
                predict_char(i_char_code);
            end
            if (o_valid && i_ready) begin
                if (reply_queue.size() == 0) begin
                    $error("unexpected result, status %0d", o_status);
                    errors++;
                end else begin
                    check_reply(reply_queue.pop_front());
                end
            end
        end
    end

    initial begin
        i_rst_n = 0;
        burst_left = 0;
        gap_left = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        fork
            begin
                wait (stim_done && reply_queue.size() == 0);
                repeat (20) @(posedge i_clk);
                if (errors == 0 && reply_queue.size() == 0) begin
                    $display("ascii_can_command_parser_tb OK");
                end else begin
                    $display("ascii_can_command_parser_tb NOT OK");
                end
            end
            begin
                wait (idle_cycles >= WatchdogLimit);
                $display("ascii_can_command_parser_tb NOT OK");
            end
        join_any
        $finish;
    end
endmodule
